FILE: hdl/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg: shared types and tables for the permutation rank/unrank block
// Holds the sequencer states, the field widths, the factorial table and the
// small helper functions used by the datapath.
// ----------------------------------------------------------------------------
package prr_pkg;

   localparam int unsigned MAX_SIZE   = 12;
   localparam int unsigned SIZE_W     = 4;
   localparam int unsigned INDEX_W    = 29;
   localparam int unsigned ELEM_W     = 4;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;

   // Command codes carried in the request tuser bit.
   localparam logic CMD_RANK   = 1'b0;
   localparam logic CMD_UNRANK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK_ADD,
      ST_RANK_END,
      ST_UNR_DEC,
      ST_UNR_CHK,
      ST_UNR_DIGIT,
      ST_UNR_DIV,
      ST_OUT
   } prr_state_type;

   // Factorial table; 12! is the largest entry and fits in the index width.
   function automatic logic [INDEX_W-1:0] fact(input logic [SIZE_W-1:0] n);
      logic [INDEX_W-1:0] f;
      unique case (n)
         4'd0:    f = 29'd1;
         4'd1:    f = 29'd1;
         4'd2:    f = 29'd2;
         4'd3:    f = 29'd6;
         4'd4:    f = 29'd24;
         4'd5:    f = 29'd120;
         4'd6:    f = 29'd720;
         4'd7:    f = 29'd5040;
         4'd8:    f = 29'd40320;
         4'd9:    f = 29'd362880;
         4'd10:   f = 29'd3628800;
         4'd11:   f = 29'd39916800;
         4'd12:   f = 29'd479001600;
         default: f = 29'd0;
      endcase
      return f;
   endfunction

   // Register value clamped into the supported permutation lengths.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] m;
      priority if (size < 4'd2) begin
         m = 4'd2;
      end else if (size > SIZE_W'(MAX_SIZE)) begin
         m = SIZE_W'(MAX_SIZE);
      end else begin
         m = size;
      end
      return m;
   endfunction

   // Lowest value above cur whose bit in mask is clear; zero if none is left.
   function automatic logic [ELEM_W-1:0] next_free(input logic [MAX_SIZE-1:0] mask,
                                                   input logic [ELEM_W-1:0]   cur);
      logic [ELEM_W-1:0] v;
      v = '0;
      for (int i = MAX_SIZE; i >= 1; i--) begin
         if ((ELEM_W'(i) > cur) && !mask[i-1]) begin
            v = ELEM_W'(i);
         end
      end
      return v;
   endfunction

endpackage

FILE: hdl/permutation_rank_unrank.sv
// ----------------------------------------------------------------------------
// permutation_rank_unrank: lexicographic permutation rank and unrank
// Converts between a permutation of 1..m and its 1-based lexicographic index
// with a single shared 29-bit add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// A rank run takes m words with tuser low, one permutation element each, and
// answers the m-th one with the 1-based index (error flag set and index zero
// if any element was out of range or repeated). An unrank word (tuser high)
// carries an index and is answered by m words of elements, tlast on the last;
// an index of zero or above m! gives m zero elements with the error flag.
// The block handles one word at a time and is not ready while it works.
// Everything goes through one add/subtract unit: for a valid rank element
// every smaller value is visited once and the factorial weight is added for
// each unused one; an invalid element skips the scan. A valid unrank index is
// first decremented and checked against m!, then each output element is found
// by repeated factorial subtraction and waits for its handshake. Writing
// perm_size restarts any rank run in progress.
module permutation_rank_unrank
   import prr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] element, [32:4] perm_index, [39:33] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [28:0] index_out, [32:29] element_out, [39:33] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // [0] error_out
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_data
);

   prr_state_type state_ff, state_in;

   logic [SIZE_W-1:0]   perm_size_ff, perm_size_in;
   logic [MAX_SIZE-1:0] used_ff, used_in;
   logic [INDEX_W-1:0]  acc_ff, acc_in;
   logic [SIZE_W-1:0]   pos_ff, pos_in;
   logic                bad_ff, bad_in;
   logic [ELEM_W-1:0]   elem_ff, elem_in;
   logic [ELEM_W-1:0]   scan_ff, scan_in;
   logic [INDEX_W-1:0]  rest_ff, rest_in;
   logic [MAX_SIZE-1:0] taken_ff, taken_in;
   logic [SIZE_W-1:0]   digit_ff, digit_in;
   logic [ELEM_W-1:0]   cand_ff, cand_in;
   logic                unrank_ff, unrank_in;
   logic                uerr_ff, uerr_in;

   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [ELEM_W-1:0]   rsp_elem_ff, rsp_elem_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_err_ff, rsp_err_in;

   logic [SIZE_W-1:0]   m;
   logic [ELEM_W-1:0]   req_elem;
   logic [INDEX_W-1:0]  req_index;
   logic [15:0]         used_wide;
   logic                elem_ok;
   logic                req_fire;
   logic                rsp_fire;
   logic                last_digit;

   // Shared add/subtract unit.
   logic [INDEX_W-1:0]  alu_a, alu_b;
   logic                alu_sub;
   logic [INDEX_W:0]    alu_res;
   logic                alu_borrow;

   assign m          = eff_size(perm_size_ff);
   assign req_elem   = req_tdata[ELEM_W-1:0];
   assign req_index  = req_tdata[ELEM_W+INDEX_W-1:ELEM_W];
   assign used_wide  = {{(16-MAX_SIZE){1'b0}}, used_ff};
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign last_digit = (digit_ff == (m - 4'd1));

   assign elem_ok = (req_elem >= 4'd1) && (req_elem <= m) &&
                    !used_wide[req_elem - 4'd1] && (pos_ff < m);

   assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                               : ({1'b0, alu_a} + {1'b0, alu_b});
   assign alu_borrow = alu_res[INDEX_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_tuser == CMD_RANK) begin
                  state_in = elem_ok ? ST_RANK_ADD : ST_RANK_END;
               end else if (req_index == '0) begin
                  state_in = ST_UNR_DIGIT;
               end else begin
                  state_in = ST_UNR_DEC;
               end
            end
         end
         ST_RANK_ADD: begin
            if (scan_ff >= elem_ff) begin
               state_in = ST_RANK_END;
            end
         end
         ST_RANK_END: begin
            state_in = ((pos_ff + 4'd1) >= m) ? ST_OUT : ST_IDLE;
         end
         ST_UNR_DEC:   state_in = ST_UNR_CHK;
         ST_UNR_CHK:   state_in = ST_UNR_DIGIT;
         ST_UNR_DIGIT: state_in = uerr_ff ? ST_OUT : ST_UNR_DIV;
         ST_UNR_DIV: begin
            if (alu_borrow) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = (unrank_ff && !last_digit) ? ST_UNR_DIGIT : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshakes and operand selection for the shared unit.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      csr_ready  = 1'b1;
      alu_a      = rest_ff;
      alu_b      = '0;
      alu_sub    = 1'b0;
      unique case (state_ff)
         ST_RANK_ADD: begin
            alu_a = acc_ff;
            alu_b = fact(m - 4'd1 - pos_ff);
         end
         ST_RANK_END: begin
            alu_a = acc_ff;
            alu_b = INDEX_W'(1);
         end
         ST_UNR_DEC: begin
            alu_b   = INDEX_W'(1);
            alu_sub = 1'b1;
         end
         ST_UNR_CHK: begin
            alu_b   = fact(m);
            alu_sub = 1'b1;
         end
         ST_UNR_DIV: begin
            alu_b   = fact(m - 4'd1 - digit_ff);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath updates.
   always_comb begin
      perm_size_in = perm_size_ff;
      used_in      = used_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      bad_in       = bad_ff;
      elem_in      = elem_ff;
      scan_in      = scan_ff;
      rest_in      = rest_ff;
      taken_in     = taken_ff;
      digit_in     = digit_ff;
      cand_in      = cand_ff;
      unrank_in    = unrank_ff;
      uerr_in      = uerr_ff;
      rsp_index_in = rsp_index_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_RANK) begin
                  unrank_in = 1'b0;
                  elem_in   = req_elem;
                  scan_in   = 4'd1;
                  if (elem_ok) begin
                     // Marking the element now does not disturb the count,
                     // which only looks at smaller values.
                     used_in = used_ff | MAX_SIZE'(16'd1 << (req_elem - 4'd1));
                  end else begin
                     bad_in = 1'b1;
                  end
               end else begin
                  unrank_in = 1'b1;
                  rest_in   = req_index;
                  taken_in  = '0;
                  digit_in  = '0;
                  uerr_in   = (req_index == '0);
               end
            end
         end
         ST_RANK_ADD: begin
            if (scan_ff < elem_ff) begin
               if (!used_wide[scan_ff - 4'd1]) begin
                  acc_in = alu_res[INDEX_W-1:0];
               end
               scan_in = scan_ff + 4'd1;
            end
         end
         ST_RANK_END: begin
            if ((pos_ff + 4'd1) >= m) begin
               rsp_index_in = bad_ff ? '0 : alu_res[INDEX_W-1:0];
               rsp_elem_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = bad_ff;
               used_in      = '0;
               acc_in       = '0;
               pos_in       = '0;
               bad_in       = 1'b0;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         ST_UNR_DEC: begin
            rest_in = alu_res[INDEX_W-1:0];
         end
         ST_UNR_CHK: begin
            // No borrow means index - 1 >= m!, so the index is too large.
            if (!alu_borrow) begin
               uerr_in = 1'b1;
            end
         end
         ST_UNR_DIGIT: begin
            cand_in = next_free(taken_ff, '0);
            if (uerr_ff) begin
               rsp_index_in = '0;
               rsp_elem_in  = '0;
               rsp_last_in  = last_digit;
               rsp_err_in   = 1'b1;
            end
         end
         ST_UNR_DIV: begin
            if (!alu_borrow) begin
               rest_in = alu_res[INDEX_W-1:0];
               cand_in = next_free(taken_ff, cand_ff);
            end else begin
               taken_in     = taken_ff | MAX_SIZE'(16'd1 << (cand_ff - 4'd1));
               rsp_index_in = '0;
               rsp_elem_in  = cand_ff;
               rsp_last_in  = last_digit;
               rsp_err_in   = 1'b0;
            end
         end
         ST_OUT: begin
            if (rsp_fire && unrank_ff && !last_digit) begin
               digit_in = digit_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase

      // A size write restarts the rank run.
      if (csr_valid && csr_ready) begin
         perm_size_in = csr_data;
         used_in      = '0;
         acc_in       = '0;
         pos_in       = '0;
         bad_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         perm_size_ff <= SIZE_W'(MAX_SIZE);
         used_ff      <= '0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         bad_ff       <= 1'b0;
         unrank_ff    <= 1'b0;
         uerr_ff      <= 1'b0;
         digit_ff     <= '0;
         taken_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         perm_size_ff <= perm_size_in;
         used_ff      <= used_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         bad_ff       <= bad_in;
         unrank_ff    <= unrank_in;
         uerr_ff      <= uerr_in;
         digit_ff     <= digit_in;
         taken_ff     <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff      <= elem_in;
      scan_ff      <= scan_in;
      rest_ff      <= rest_in;
      cand_ff      <= cand_in;
      rsp_index_ff <= rsp_index_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tdata = {{(RSP_DATA_W-INDEX_W-ELEM_W){1'b0}}, rsp_elem_ff, rsp_index_ff};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_err_ff;

   // The block never takes a word while a result is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   // The block is not ready again in the cycle after it takes a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready stayed high after an accepted word");

   // Flagged results carry neither an index nor an element.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[INDEX_W+ELEM_W-1:0] == '0))
      else $error("error result with nonzero payload");

   // An element result never carries an index as well.
   a_elem_no_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[INDEX_W+ELEM_W-1:INDEX_W] != '0))
         |-> (rsp_tdata[INDEX_W-1:0] == '0))
      else $error("element result with nonzero index");

endmodule
